// File: sv/ll1e_pkg.sv
// Package: token, symbol, rule and status codes plus the LL(1) parse table.
`timescale 1ns / 1ps
package ll1e_pkg;

  typedef logic [2:0]  kind_t;
  typedef logic [3:0]  sym_t;
  typedef logic [2:0]  rule_t;
  typedef logic [1:0]  status_t;
  typedef logic [30:0] number_t;
  typedef logic signed [31:0] value_t;

  typedef struct packed {
    logic  ok;
    rule_t rule;
  } rule_sel_t;

  // terminals share their codes with token kinds
  localparam kind_t K_NUM     = 3'd0;
  localparam kind_t K_PLUS    = 3'd1;
  localparam kind_t K_STAR    = 3'd2;
  localparam kind_t K_LP      = 3'd3;
  localparam kind_t K_RP      = 3'd4;
  localparam kind_t K_END     = 3'd5;
  localparam kind_t K_UNKNOWN = 3'd6;

  localparam sym_t S_NUM   = 4'd0;
  localparam sym_t S_PLUS  = 4'd1;
  localparam sym_t S_STAR  = 4'd2;
  localparam sym_t S_LP    = 4'd3;
  localparam sym_t S_RP    = 4'd4;
  localparam sym_t N_STMT  = 4'd7;
  localparam sym_t N_EXPR  = 4'd8;
  localparam sym_t N_EXPRP = 4'd9;
  localparam sym_t N_TERM  = 4'd10;
  localparam sym_t N_TERMP = 4'd11;
  localparam sym_t N_FACT  = 4'd12;
  localparam sym_t A_ADD   = 4'd13;
  localparam sym_t A_MUL   = 4'd14;

  localparam rule_t R_STMT    = 3'd0;
  localparam rule_t R_EXPR    = 3'd1;
  localparam rule_t R_EXPRP   = 3'd2;
  localparam rule_t R_TERM    = 3'd3;
  localparam rule_t R_TERMP   = 3'd4;
  localparam rule_t R_FACT_N  = 3'd5;
  localparam rule_t R_FACT_P  = 3'd6;
  localparam rule_t R_EPSILON = 3'd7;

  localparam status_t ST_OK            = 2'd0;
  localparam status_t ST_SYNTAX        = 2'd1;
  localparam status_t ST_UNKNOWN_FIRST = 2'd2;
  localparam status_t ST_OVERFLOW      = 2'd3;

  // parse table: nonterminal row, token kind column
  function automatic rule_sel_t rule_lookup(sym_t nt, kind_t kind);
    rule_sel_t r;
    r.ok   = 1'b0;
    r.rule = R_EPSILON;
    case (nt)
      N_STMT: begin
        if (kind == K_NUM || kind == K_LP) begin
          r.ok = 1'b1; r.rule = R_STMT;
        end else if (kind == K_END) begin
          r.ok = 1'b1; r.rule = R_EPSILON;
        end
      end
      N_EXPR: begin
        if (kind == K_NUM || kind == K_LP) begin
          r.ok = 1'b1; r.rule = R_EXPR;
        end
      end
      N_EXPRP: begin
        r.ok   = 1'b1;
        r.rule = (kind == K_PLUS) ? R_EXPRP : R_EPSILON;
      end
      N_TERM: begin
        if (kind == K_NUM || kind == K_LP) begin
          r.ok = 1'b1; r.rule = R_TERM;
        end
      end
      N_TERMP: begin
        r.ok   = 1'b1;
        r.rule = (kind == K_STAR) ? R_TERMP : R_EPSILON;
      end
      N_FACT: begin
        if (kind == K_NUM) begin
          r.ok = 1'b1; r.rule = R_FACT_N;
        end else if (kind == K_LP) begin
          r.ok = 1'b1; r.rule = R_FACT_P;
        end
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] rhs_len(rule_t rule);
    logic [2:0] n;
    case (rule)
      R_STMT:   n = 3'd1;
      R_EXPR:   n = 3'd2;
      R_EXPRP:  n = 3'd4;
      R_TERM:   n = 3'd2;
      R_TERMP:  n = 3'd4;
      R_FACT_N: n = 3'd1;
      R_FACT_P: n = 3'd3;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  // right-hand side in push order; the last one pushed is popped first
  function automatic sym_t rhs_sym(rule_t rule, logic [1:0] idx);
    sym_t s;
    s = S_NUM;
    case (rule)
      R_STMT:   s = N_EXPR;
      R_EXPR:   s = (idx == 2'd0) ? N_EXPRP : N_TERM;
      R_EXPRP: begin
        case (idx)
          2'd0:    s = A_ADD;
          2'd1:    s = N_EXPRP;
          2'd2:    s = N_TERM;
          default: s = S_PLUS;
        endcase
      end
      R_TERM:   s = (idx == 2'd0) ? N_TERMP : N_FACT;
      R_TERMP: begin
        case (idx)
          2'd0:    s = A_MUL;
          2'd1:    s = N_TERMP;
          2'd2:    s = N_FACT;
          default: s = S_STAR;
        endcase
      end
      R_FACT_N: s = S_NUM;
      R_FACT_P: begin
        case (idx)
          2'd0:    s = S_RP;
          2'd1:    s = N_EXPR;
          default: s = S_LP;
        endcase
      end
      default:  s = S_NUM;
    endcase
    return s;
  endfunction

endpackage

// File: sv/ll1e_if.sv
// Interfaces: token channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
interface ll1e_token_if;
  logic              valid;
  logic              ready;
  ll1e_pkg::kind_t   token_kind;
  ll1e_pkg::number_t token_number;

  modport source (output valid, output token_kind, output token_number, input ready);
  modport sink   (input valid, input token_kind, input token_number, output ready);
endinterface

interface ll1e_result_if;
  logic              valid;
  logic              ready;
  ll1e_pkg::value_t  result_value;
  ll1e_pkg::status_t status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// File: sv/ll1_expression_evaluator.sv
// Top level: table-driven LL(1) evaluator with symbol and operand stacks in memory.
//
//   channel  | modport | transfer moves
//   ---------+---------+---------------------------------------------
//   tok_i    | sink    | one token: token_kind (3b), token_number (31b)
//   res_o    | source  | one result: result_value (32b signed), status (2b)
//
// Flow: a token is taken in IDLE; each stack symbol then passes through POP and
// EXEC, an expansion writes its symbols in PUSH, and EMIT follows when a
// statement ends. The pop/expand loop over the symbol memory is serial.
// Reset puts stmt in the cached top-of-stack register, so no memory clearing.
// A result waits in the output register; IDLE still takes a token, EMIT holds.
`timescale 1ns / 1ps
module ll1_expression_evaluator #(
  parameter int SYMBOL_STACK_DEPTH  = 32,
  parameter int OPERAND_STACK_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ll1e_token_if.sink        tok_i,
  ll1e_result_if.source     res_o
);

  localparam int SymAw = $clog2(SYMBOL_STACK_DEPTH);
  localparam int SymDw = $clog2(SYMBOL_STACK_DEPTH + 1);
  localparam int OpdAw = $clog2(OPERAND_STACK_DEPTH);
  localparam int OpdDw = $clog2(OPERAND_STACK_DEPTH + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPop  = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StPush = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  // control state
  logic [2:0]            state_q, state_d;
  logic [SymDw-1:0]      sym_depth_q, sym_depth_d;
  logic                  top_vld_q, top_vld_d;   // top symbol held in register
  logic [OpdDw-1:0]      opd_depth_q, opd_depth_d;
  logic                  first_q, first_d;
  logic                  from_mem_q, from_mem_d;
  logic [1:0]            push_idx_q, push_idx_d;
  logic                  out_valid_q, out_valid_d;

  // payload registers
  ll1e_pkg::sym_t        top_q, top_d;
  ll1e_pkg::kind_t       kind_q, kind_d;
  ll1e_pkg::number_t     num_q, num_d;
  ll1e_pkg::rule_t       rule_q, rule_d;
  ll1e_pkg::status_t     emit_status_q, emit_status_d;
  logic [31:0]           opd_top_q, opd_top_d;   // cached operand stack top
  logic [31:0]           out_value_q, out_value_d;
  ll1e_pkg::status_t     out_status_q, out_status_d;

  // symbol memory
  ll1e_pkg::sym_t        sym_mem [SYMBOL_STACK_DEPTH];
  ll1e_pkg::sym_t        sym_rd_q;
  logic                  sym_re, sym_we;
  logic [SymAw-1:0]      sym_ra, sym_wa;
  ll1e_pkg::sym_t        sym_wd;

  // operand memory
  logic [31:0]           opd_mem [OPERAND_STACK_DEPTH];
  logic [31:0]           opd_rd_q;
  logic                  opd_re, opd_we;
  logic [OpdAw-1:0]      opd_ra, opd_wa;
  logic [31:0]           opd_wd;

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    if (sym_re) begin
      sym_rd_q <= sym_mem[sym_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (opd_we) begin
      opd_mem[opd_wa] <= opd_wd;
    end
    if (opd_re) begin
      opd_rd_q <= opd_mem[opd_ra];
    end
  end

  // handshake
  logic tok_xfer, res_xfer, out_free;
  assign tok_i.ready = (state_q == StIdle);
  assign tok_xfer    = tok_i.valid && tok_i.ready;
  assign res_xfer    = out_valid_q && res_o.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  assign res_o.valid        = out_valid_q;
  assign res_o.result_value = out_value_q;
  assign res_o.status       = out_status_q;

  // kind code seven behaves as unknown
  ll1e_pkg::kind_t kind_in;
  assign kind_in = (tok_i.token_kind > ll1e_pkg::K_UNKNOWN) ? ll1e_pkg::K_UNKNOWN
                                                             : tok_i.token_kind;

  // EXEC operands
  ll1e_pkg::sym_t     cur_sym;
  ll1e_pkg::rule_sel_t sel;
  logic [2:0]         push_len;
  ll1e_pkg::sym_t     push_sym;
  logic [31:0]        opd_a, opd_b, opd_sum, opd_prod;

  assign cur_sym  = from_mem_q ? sym_rd_q : top_q;
  assign sel      = ll1e_pkg::rule_lookup(cur_sym, kind_q);
  assign push_len = ll1e_pkg::rhs_len(rule_q);
  assign push_sym = ll1e_pkg::rhs_sym(rule_q, push_idx_q);
  // a missing operand reads as zero
  assign opd_a    = (opd_depth_q >= OpdDw'(1)) ? opd_top_q : 32'd0;
  assign opd_b    = (opd_depth_q >= OpdDw'(2)) ? opd_rd_q : 32'd0;
  assign opd_sum  = opd_a + opd_b;
  assign opd_prod = opd_a * opd_b;

  always_comb begin
    state_d       = state_q;
    sym_depth_d   = sym_depth_q;
    top_vld_d     = top_vld_q;
    opd_depth_d   = opd_depth_q;
    first_d       = first_q;
    from_mem_d    = from_mem_q;
    push_idx_d    = push_idx_q;
    top_d         = top_q;
    kind_d        = kind_q;
    num_d         = num_q;
    rule_d        = rule_q;
    emit_status_d = emit_status_q;
    opd_top_d     = opd_top_q;
    out_valid_d   = out_valid_q && !res_xfer;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;

    sym_re = 1'b0;
    sym_ra = sym_depth_q[SymAw-1:0] - SymAw'(1);
    sym_we = 1'b0;
    sym_wa = sym_depth_q[SymAw-1:0];
    sym_wd = push_sym;
    opd_re = 1'b0;
    opd_ra = opd_depth_q[OpdAw-1:0] - OpdAw'(2);
    opd_we = 1'b0;
    opd_wa = opd_depth_q[OpdAw-1:0];
    opd_wd = {1'b0, num_q};

    case (state_q)
      StIdle: begin
        if (tok_xfer) begin
          kind_d = kind_in;
          num_d  = tok_i.token_number;
          if (first_q && kind_in == ll1e_pkg::K_UNKNOWN) begin
            // operand stack is empty right after a restart, so value is zero
            emit_status_d = ll1e_pkg::ST_UNKNOWN_FIRST;
            state_d       = StEmit;
          end else begin
            first_d = 1'b0;
            state_d = StPop;
          end
        end
      end

      StPop: begin
        if (sym_depth_q == '0) begin
          emit_status_d = ll1e_pkg::ST_OK;
          state_d       = StEmit;
        end else begin
          // second operand fetched ahead in case the symbol is an action
          opd_re      = 1'b1;
          from_mem_d  = !top_vld_q;
          sym_re      = !top_vld_q;
          top_vld_d   = 1'b0;
          sym_depth_d = sym_depth_q - SymDw'(1);
          state_d     = StExec;
        end
      end

      StExec: begin
        if (cur_sym >= ll1e_pkg::A_ADD) begin
          opd_we    = 1'b1;
          opd_wd    = (cur_sym == ll1e_pkg::A_ADD) ? opd_sum : opd_prod;
          opd_top_d = opd_wd;
          if (opd_depth_q >= OpdDw'(2)) begin
            opd_wa      = opd_ra;
            opd_depth_d = opd_depth_q - OpdDw'(1);
          end else begin
            opd_wa      = '0;
            opd_depth_d = OpdDw'(1);
          end
          state_d = StPop;
        end else if (cur_sym >= ll1e_pkg::N_STMT) begin
          if (!sel.ok) begin
            emit_status_d = ll1e_pkg::ST_SYNTAX;
            state_d       = StEmit;
          end else if (ll1e_pkg::rhs_len(sel.rule) == 3'd0) begin
            state_d = StPop;
          end else begin
            rule_d     = sel.rule;
            push_idx_d = 2'd0;
            state_d    = StPush;
          end
        end else begin
          // terminal match
          if ({1'b0, kind_q} != cur_sym) begin
            emit_status_d = ll1e_pkg::ST_SYNTAX;
            state_d       = StEmit;
          end else if (kind_q == ll1e_pkg::K_NUM &&
                       opd_depth_q >= OpdDw'(OPERAND_STACK_DEPTH)) begin
            emit_status_d = ll1e_pkg::ST_OVERFLOW;
            state_d       = StEmit;
          end else begin
            if (kind_q == ll1e_pkg::K_NUM) begin
              opd_we      = 1'b1;
              opd_top_d   = {1'b0, num_q};
              opd_depth_d = opd_depth_q + OpdDw'(1);
            end
            if (sym_depth_q == '0) begin
              emit_status_d = ll1e_pkg::ST_OK;
              state_d       = StEmit;
            end else begin
              state_d = StIdle;
            end
          end
        end
      end

      StPush: begin
        if (sym_depth_q >= SymDw'(SYMBOL_STACK_DEPTH)) begin
          emit_status_d = ll1e_pkg::ST_OVERFLOW;
          state_d       = StEmit;
        end else if ({1'b0, push_idx_q} == push_len - 3'd1) begin
          // last symbol stays in the top register; it is popped next
          top_d       = push_sym;
          top_vld_d   = 1'b1;
          sym_depth_d = sym_depth_q + SymDw'(1);
          state_d     = StPop;
        end else begin
          sym_we      = 1'b1;
          sym_depth_d = sym_depth_q + SymDw'(1);
          push_idx_d  = push_idx_q + 2'd1;
        end
      end

      StEmit: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = (opd_depth_q != '0) ? opd_top_q : 32'd0;
          out_status_d = emit_status_q;
          // restart: stmt alone on the symbol stack
          top_d        = ll1e_pkg::N_STMT;
          top_vld_d    = 1'b1;
          sym_depth_d  = SymDw'(1);
          opd_depth_d  = '0;
          first_d      = 1'b1;
          state_d      = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sym_depth_q <= SymDw'(1);
      top_vld_q   <= 1'b1;
      top_q       <= ll1e_pkg::N_STMT;
      opd_depth_q <= '0;
      first_q     <= 1'b1;
      from_mem_q  <= 1'b0;
      push_idx_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sym_depth_q <= sym_depth_d;
      top_vld_q   <= top_vld_d;
      top_q       <= top_d;
      opd_depth_q <= opd_depth_d;
      first_q     <= first_d;
      from_mem_q  <= from_mem_d;
      push_idx_q  <= push_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    num_q         <= num_d;
    rule_q        <= rule_d;
    emit_status_q <= emit_status_d;
    opd_top_q     <= opd_top_d;
    out_value_q   <= out_value_d;
    out_status_q  <= out_status_d;
  end

endmodule

// File: bench/ll1e_result_checker.sv
// Checker: shadow LL(1) evaluator fed by token transfers, compares every result transfer.
`timescale 1ns / 1ps
module ll1e_result_checker #(
  parameter int SYMBOL_STACK_DEPTH  = 32,
  parameter int OPERAND_STACK_DEPTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ll1e_token_if  tok_i,
  ll1e_result_if res_i,
  output int     pending_o,
  output int     fail_count_o
);
  import ll1e_pkg::*;

  typedef struct packed {
    value_t  value;
    status_t status;
  } outcome_t;

  // right-hand side, element 0 pushed first
  typedef logic [3:0][3:0] rhs_t;

  sym_t        sym_stack  [SYMBOL_STACK_DEPTH];
  int          sym_depth;
  logic [31:0] opnd_stack [OPERAND_STACK_DEPTH];
  int          opnd_depth;
  bit          at_first;
  outcome_t    expected_results [$];
  int          fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void restart_stmt();
    sym_stack[0] = N_STMT;
    sym_depth    = 1;
    opnd_depth   = 0;
    at_first     = 1'b1;
  endfunction

  // empty operand stack reads as zero
  function automatic logic [31:0] pop_operand();
    if (opnd_depth == 0) return '0;
    opnd_depth--;
    return opnd_stack[opnd_depth];
  endfunction

  function automatic outcome_t finish_stmt(status_t st);
    outcome_t o;
    o.value  = (opnd_depth > 0) ? value_t'(opnd_stack[opnd_depth-1]) : '0;
    o.status = st;
    restart_stmt();
    return o;
  endfunction

  // parse table; returns 0 on a missing entry
  function automatic bit expand(sym_t nt, kind_t kind, output rhs_t rhs, output int n);
    bit leads;
    bit ok;
    leads = (kind == K_NUM) || (kind == K_LP);
    rhs   = '0;
    n     = 0;
    ok    = leads;
    case (nt)
      N_STMT: begin
        if (leads) begin
          rhs[0] = N_EXPR;
          n      = 1;
        end
        ok = leads || (kind == K_END);
      end
      N_EXPR: begin
        if (leads) begin
          rhs = {S_NUM, S_NUM, N_TERM, N_EXPRP};
          n   = 2;
        end
      end
      N_EXPRP: begin
        ok = 1'b1;
        if (kind == K_PLUS) begin
          rhs = {S_PLUS, N_TERM, N_EXPRP, A_ADD};
          n   = 4;
        end
      end
      N_TERM: begin
        if (leads) begin
          rhs = {S_NUM, S_NUM, N_FACT, N_TERMP};
          n   = 2;
        end
      end
      N_TERMP: begin
        ok = 1'b1;
        if (kind == K_STAR) begin
          rhs = {S_STAR, N_FACT, N_TERMP, A_MUL};
          n   = 4;
        end
      end
      N_FACT: begin
        if (kind == K_NUM) begin
          rhs[0] = S_NUM;
          n      = 1;
        end else if (kind == K_LP) begin
          rhs = {S_NUM, S_LP, N_EXPR, S_RP};
          n   = 3;
        end
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // runs the pop/expand/match loop for one token; 1 when a result is due
  function automatic bit evaluate_token(kind_t raw_kind, number_t number, output outcome_t o);
    kind_t       kind;
    sym_t        top;
    rhs_t        rhs;
    int          n;
    int          i;
    logic [31:0] a;
    logic [31:0] b;
    bit          done;
    bit          got_result;
    kind       = (raw_kind > K_UNKNOWN) ? K_UNKNOWN : raw_kind;
    o          = '0;
    done       = 1'b0;
    got_result = 1'b0;
    if (at_first && kind == K_UNKNOWN) begin
      o.status = ST_UNKNOWN_FIRST;
      restart_stmt();
      return 1'b1;
    end
    at_first = 1'b0;
    while (!done) begin
      if (sym_depth == 0) begin
        o          = finish_stmt(ST_OK);
        got_result = 1'b1;
        done       = 1'b1;
      end else begin
        sym_depth--;
        top = sym_stack[sym_depth];
        if (top >= A_ADD) begin
          a = pop_operand();
          b = pop_operand();
          opnd_stack[opnd_depth] = (top == A_ADD) ? a + b : a * b;
          opnd_depth++;
        end else if (top >= N_STMT) begin
          if (!expand(top, kind, rhs, n)) begin
            o          = finish_stmt(ST_SYNTAX);
            got_result = 1'b1;
            done       = 1'b1;
          end else begin
            for (i = 0; i < n && !done; i++) begin
              if (sym_depth >= SYMBOL_STACK_DEPTH) begin
                o          = finish_stmt(ST_OVERFLOW);
                got_result = 1'b1;
                done       = 1'b1;
              end else begin
                sym_stack[sym_depth] = rhs[i];
                sym_depth++;
              end
            end
          end
        end else begin
          // terminal: match consumes the token either way
          done = 1'b1;
          if (top != {1'b0, kind}) begin
            o          = finish_stmt(ST_SYNTAX);
            got_result = 1'b1;
          end else if (kind == K_NUM && opnd_depth >= OPERAND_STACK_DEPTH) begin
            o          = finish_stmt(ST_OVERFLOW);
            got_result = 1'b1;
          end else begin
            if (kind == K_NUM) begin
              opnd_stack[opnd_depth] = {1'b0, number};
              opnd_depth++;
            end
            if (sym_depth == 0) begin
              o          = finish_stmt(ST_OK);
              got_result = 1'b1;
            end
          end
        end
      end
    end
    return got_result;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    outcome_t fresh;
    if (!rst_ni) begin
      restart_stmt();
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // result first: a token taken at this edge cannot have produced it
      if (res_i.valid && res_i.ready) begin
        got.value  = res_i.result_value;
        got.status = res_i.status;
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result value %0d status %0d", got.value, got.status));
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value)
            report($sformatf("result_value got %0d want %0d", got.value, want.value));
          if (got.status !== want.status)
            report($sformatf("status got %0d want %0d", got.status, want.status));
        end
      end
      if (tok_i.valid && tok_i.ready) begin
        if (evaluate_token(tok_i.token_kind, tok_i.token_number, fresh))
          expected_results.push_back(fresh);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: bench/tb_ll1_expression_evaluator.sv
// Testbench top: clock, reset, token stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_ll1_expression_evaluator;
  import ll1e_pkg::*;

  localparam int SYM_DEPTH   = 32;
  localparam int OPND_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_ITEMS  = 1600;  // no idling past this point
  localparam int TAIL_CYCLES  = 200;   // longest pop/action run of one token, with margin

  typedef struct packed {
    kind_t   kind;
    number_t number;
  } token_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ll1e_token_if  tok_if ();
  ll1e_result_if res_if ();

  int     pending;
  int     fail_count;
  int     gap_pct   = 0;   // sender idle chance per token, percent
  int     stall_pct = 0;   // receiver stall chance per cycle, percent
  int     sent_count = 0;
  token_t stmt_tokens [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ll1_expression_evaluator #(
    .SYMBOL_STACK_DEPTH  (SYM_DEPTH),
    .OPERAND_STACK_DEPTH (OPND_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_if),
    .res_o  (res_if)
  );

  ll1e_result_checker #(
    .SYMBOL_STACK_DEPTH  (SYM_DEPTH),
    .OPERAND_STACK_DEPTH (OPND_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_i        (tok_if),
    .res_i        (res_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Mix of extremes, small values and full-width noise.
  function automatic number_t rand_number();
    number_t v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = number_t'($urandom_range(0, 9));
      default: v = number_t'($urandom);
    endcase
    return v;
  endfunction

  function automatic void add_token(kind_t kind, number_t number);
    token_t t;
    t.kind   = kind;
    t.number = number;
    stmt_tokens.push_back(t);
  endfunction

  // Well-formed sum of products; parenthesized factors down to the given depth.
  function automatic void build_expr(int depth);
    int terms;
    int factors;
    int i;
    int j;
    terms = $urandom_range(1, 4);
    for (i = 0; i < terms; i++) begin
      if (i > 0) add_token(K_PLUS, rand_number());
      factors = $urandom_range(1, 3);
      for (j = 0; j < factors; j++) begin
        if (j > 0) add_token(K_STAR, rand_number());
        if (depth > 0 && $urandom_range(0, 3) == 0) begin
          add_token(K_LP, rand_number());
          build_expr(depth - 1);
          add_token(K_RP, rand_number());
        end else begin
          add_token(K_NUM, rand_number());
        end
      end
    end
  endfunction

  // One token transfer; an optional idle burst goes in front of it.
  // valid stays high across back-to-back transfers.
  task automatic send_token(kind_t kind, number_t number);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      tok_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    tok_if.valid        <= 1'b1;
    tok_if.token_kind   <= kind;
    tok_if.token_number <= number;
    do @(posedge clk_i); while (!tok_if.ready);
    sent_count++;
  endtask

  task automatic send_stmt();
    foreach (stmt_tokens[i]) send_token(stmt_tokens[i].kind, stmt_tokens[i].number);
    stmt_tokens.delete();
  endtask

  // Sender holds off until every expected result has been transferred.
  task automatic drain();
    tok_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result side back-pressure in random bursts.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  // The limit allows for the slowest legal run of about 1.8k tokens with sender
  // idling and result stalls, with margin.
  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int   choice;
    int   len;
    int   idx;
    int   random_start;
    int   next_drain;
    kind_t op;

    tok_if.valid        <= 1'b0;
    tok_if.token_kind   <= K_END;
    tok_if.token_number <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part: no idling ----
    // unknown as the first token, both codes
    add_token(K_UNKNOWN, rand_number());
    add_token(kind_t'(3'd7), '1);
    // empty statement
    add_token(K_END, '0);
    // product that wraps at 32 bits
    add_token(K_NUM, '1);
    add_token(K_STAR, '0);
    add_token(K_NUM, '1);
    add_token(K_END, '1);
    // parenthesized sum crossing into the sign bit
    add_token(K_LP, '0);
    add_token(K_NUM, '1);
    add_token(K_PLUS, '1);
    add_token(K_NUM, number_t'(1));
    add_token(K_RP, '0);
    add_token(K_END, '0);
    // no table entry for a leading plus
    add_token(K_PLUS, '0);
    // closing paren missing: terminal mismatch with an operand on the stack
    add_token(K_LP, '0);
    add_token(K_NUM, number_t'(5));
    add_token(K_END, '0);
    // a number right after a complete one ends the statement and is consumed
    add_token(K_NUM, '0);
    add_token(K_NUM, number_t'(9));
    // unknown after a complete expression closes it normally
    add_token(K_NUM, number_t'(3));
    add_token(K_UNKNOWN, '0);
    // dangling star: factor missing at end of input
    add_token(K_NUM, number_t'(2));
    add_token(K_STAR, '0);
    add_token(K_END, '0);
    send_stmt();
    drain();

    // ---- random part ----
    random_start = sent_count;
    next_drain   = 300;
    while (sent_count - random_start < RANDOM_ITEMS) begin
      if (sent_count - random_start >= QUIET_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        // new idling regime, including stretches with none
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end

      choice = $urandom_range(0, 99);
      if (choice < 60) begin
        // well-formed statement, usually closed by end of input
        build_expr($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0)
          add_token(kind_t'($urandom_range(K_UNKNOWN, 7)), rand_number());
        else
          add_token(K_END, rand_number());
      end else if (choice < 68) begin
        // flat chain: pending actions pile up, long ones overflow the operand stack
        len = $urandom_range(12, 20);
        op  = ($urandom_range(0, 1) == 0) ? K_PLUS : K_STAR;
        for (int i = 0; i < len; i++) begin
          if (i > 0) add_token(op, rand_number());
          add_token(K_NUM, rand_number());
        end
        add_token(K_END, rand_number());
      end else if (choice < 74) begin
        // deep nesting: overflows the symbol stack at ten levels
        len = $urandom_range(4, 10);
        repeat (len) add_token(K_LP, rand_number());
        add_token(K_NUM, rand_number());
        repeat (len) add_token(K_RP, rand_number());
        add_token(K_END, rand_number());
      end else if (choice < 80) begin
        // empty statement or unknown first token
        add_token(kind_t'($urandom_range(K_END, 7)), rand_number());
      end else if (choice < 90) begin
        // broken statement: one token replaced or dropped
        build_expr($urandom_range(0, 2));
        if (stmt_tokens.size() > 1 && $urandom_range(0, 1) == 0) begin
          stmt_tokens.delete($urandom_range(0, stmt_tokens.size() - 1));
        end else begin
          idx = $urandom_range(0, stmt_tokens.size() - 1);
          stmt_tokens[idx].kind = kind_t'($urandom_range(0, 7));
        end
        add_token(K_END, rand_number());
      end else begin
        // noise; a trailing end of input always closes whatever is open
        repeat ($urandom_range(1, 6)) add_token(kind_t'($urandom_range(0, 7)), rand_number());
        add_token(K_END, rand_number());
      end
      send_stmt();

      if (sent_count - random_start >= next_drain) begin
        drain();
        next_drain += 300;
      end
    end

    // ---- wrap-up ----
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
